/* src/sfr_pkg.sv */
// Shared constants, phase encoding and result type for the serial frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

  // Frame format constants.
  localparam logic [7:0] HDR_BYTE    = 8'hAA;
  localparam logic [7:0] FN_HEIGHT   = 8'h01;
  localparam logic [7:0] FN_ATTITUDE = 8'h02;

  // Payload length and store size.
  localparam int         STORE_DEPTH   = 12;
  localparam logic [3:0] PAYLOAD_BYTES = 4'd12;

  // Frame kind codes on the result word.
  localparam logic KIND_HEIGHT   = 1'b0;
  localparam logic KIND_ATTITUDE = 1'b1;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HUNT1  = 3'd0,
    PH_HUNT2  = 3'd1,
    PH_FUNC   = 3'd2,
    PH_HEIGHT = 3'd3,
    PH_ATT    = 3'd4
  } sfr_phase_t;

  // One finished frame as produced by the parser.
  typedef struct packed {
    logic        valid;
    logic        frame_kind;
    logic [31:0] word_first;
    logic [31:0] word_second;
    logic [31:0] word_third;
  } sfr_result_t;

endpackage

/* src/sfr_parser.sv */
// Header hunting state machine and payload store of the serial frame receiver.
`timescale 1ns / 1ps

module sfr_parser
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output sfr_result_t result
);

  sfr_phase_t  phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [7:0]  store_r [STORE_DEPTH];
  logic [7:0]  cur_byte [STORE_DEPTH];
  logic        store_we;
  logic        in_payload;
  logic [3:0]  count_inc;
  logic        last_byte;

  assign in_payload = (phase_r == PH_HEIGHT) || (phase_r == PH_ATT);
  assign count_inc  = count_r + 4'd1;
  assign last_byte  = count_inc >= PAYLOAD_BYTES;
  assign store_we   = step && in_payload && (count_r < 4'(STORE_DEPTH));

  // Next phase and payload count for the word being parsed.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    if (step) begin
      case (phase_r)
        PH_HUNT1: begin
          phase_nxt = (rx_byte == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
        end
        PH_HUNT2: begin
          phase_nxt = (rx_byte == HDR_BYTE) ? PH_FUNC : PH_HUNT1;
        end
        PH_FUNC: begin
          if (rx_byte == FN_HEIGHT) begin
            phase_nxt = PH_HEIGHT;
            count_nxt = 4'd0;
          end else if (rx_byte == FN_ATTITUDE) begin
            phase_nxt = PH_ATT;
            count_nxt = 4'd0;
          end else begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_HEIGHT, PH_ATT: begin
          count_nxt = count_inc;
          if (last_byte) begin
            phase_nxt = PH_HUNT1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT1;
        end
      endcase
    end
  end

  // Store contents as seen with the current word already written.
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      cur_byte[i] = (store_we && (count_r == 4'(i))) ? rx_byte : store_r[i];
    end
  end

  // Result assembly: three little-endian words out of the payload.
  always_comb begin
    result.valid       = step && in_payload && last_byte;
    result.frame_kind  = (phase_r == PH_ATT) ? KIND_ATTITUDE : KIND_HEIGHT;
    result.word_first  = {cur_byte[3], cur_byte[2], cur_byte[1], cur_byte[0]};
    result.word_second = {cur_byte[7], cur_byte[6], cur_byte[5], cur_byte[4]};
    result.word_third  = {cur_byte[11], cur_byte[10], cur_byte[9], cur_byte[8]};
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      count_r <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload store, written at the current count.
  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (store_we && (count_r == 4'(i))) begin
        store_r[i] <= rx_byte;
      end
    end
  end

endmodule

/* src/serial_frame_receiver_unit.sv */
// Serial frame receiver: finds 0xAA 0xAA headers and emits height or attitude frames.
// Path: input register, then the combinational parser, then the result register.
// Throughput: one word per cycle unless the output stalls; the whole path advances together.
// Intake pauses only while a finished result waits in the result register and out_ready is low.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to header hunt.
`timescale 1ns / 1ps

module serial_frame_receiver_unit
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_kind,
  output logic [31:0] out_word_first,
  output logic [31:0] out_word_second,
  output logic [31:0] out_word_third
);

  logic        s1_vld_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  logic        out_kind_r;
  logic [31:0] out_w0_r;
  logic [31:0] out_w1_r;
  logic [31:0] out_w2_r;
  logic        advance;
  logic        step;
  sfr_result_t res;

  // The pipeline moves unless a result sits unclaimed at the output.
  assign advance  = !out_valid_r || out_ready;
  assign step     = s1_vld_r && advance;
  assign in_ready = !s1_vld_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  sfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte_r),
    .result  (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_kind_r <= res.frame_kind;
      out_w0_r   <= res.word_first;
      out_w1_r   <= res.word_second;
      out_w2_r   <= res.word_third;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_kind  = out_kind_r;
  assign out_word_first  = out_w0_r;
  assign out_word_second = out_w1_r;
  assign out_word_third  = out_w2_r;

`ifndef SYNTHESIS
  // An empty result register never blocks intake.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("in_ready low while result register is empty");

  // A new result comes only from a word that sat in the input register.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_vld_r))
    else $error("result appeared without a buffered word");

  // A stalled output keeps the buffered word in place.
  a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && s1_vld_r) |=> (s1_vld_r && $stable(s1_byte_r)))
    else $error("buffered word lost during output stall");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the serial frame receiver, with a built-in frame predictor.
`timescale 1ns / 1ps

module testbench;
  import sfr_pkg::*;

  // One finished frame as seen on the result channel.
  typedef struct packed {
    logic        frame_kind;
    logic [31:0] word_first;
    logic [31:0] word_second;
    logic [31:0] word_third;
  } frame_t;

  // A stimulus word, with the frame it completes when that frame is typed in by hand.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       known;
    frame_t     frame;
  } stim_row_t;

  // Hand-typed frame carried alongside each word until the word is accepted.
  typedef struct packed {
    logic   known;
    frame_t frame;
  } typed_frame_t;

  localparam frame_t NO_FRAME     = '0;
  localparam int     DIR_ROWS     = 21;
  localparam int     ITEM_TARGET  = 450;
  localparam int     LONG_HOLD    = 300;
  localparam int     CYCLE_LIMIT  = 200000;

  // Directed rows: header faults first, then one height frame with extreme payload bytes.
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{8'hFF, 1'b0, NO_FRAME},
    '{HDR_BYTE, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{HDR_BYTE, 1'b0, NO_FRAME},
    '{HDR_BYTE, 1'b0, NO_FRAME},
    '{HDR_BYTE, 1'b0, NO_FRAME},
    '{HDR_BYTE, 1'b0, NO_FRAME},
    '{HDR_BYTE, 1'b0, NO_FRAME},
    '{FN_HEIGHT, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h01, 1'b0, NO_FRAME},
    '{8'h02, 1'b0, NO_FRAME},
    '{8'h03, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFE, 1'b0, NO_FRAME},
    '{8'hFD, 1'b0, NO_FRAME},
    '{8'hFC, 1'b0, NO_FRAME},
    '{8'h80, 1'b0, NO_FRAME},
    '{8'h7F, 1'b0, NO_FRAME},
    '{8'h55, 1'b0, NO_FRAME},
    '{HDR_BYTE, 1'b1, '{KIND_HEIGHT, 32'h03020100, 32'hFCFDFEFF, 32'hAA557F80}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_frame_kind;
  logic [31:0] out_word_first;
  logic [31:0] out_word_second;
  logic [31:0] out_word_third;

  // Predictor state.
  sfr_phase_t  rx_phase;
  logic [3:0]  rx_count;
  logic [7:0]  rx_store [STORE_DEPTH];

  frame_t       pending_frames [$];
  typed_frame_t typed_frames [$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  height_checked = 0;
  int  attitude_checked = 0;
  int  burst_left = 0;
  bit  no_gaps = 1'b0;
  bit  hold_req = 1'b0;

  serial_frame_receiver_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_kind  (out_frame_kind),
    .out_word_first  (out_word_first),
    .out_word_second (out_word_second),
    .out_word_third  (out_word_third)
  );

  always #6 clk = ~clk;

  // Advance the frame parser by one received byte; returns 1 when a frame completes.
  function automatic bit parse_rx_byte(input logic [7:0] b, output frame_t frame);
    bit done;
    done = 1'b0;
    frame = NO_FRAME;
    case (rx_phase)
      PH_HUNT1: begin
        rx_phase = (b == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
      PH_HUNT2: begin
        rx_phase = (b == HDR_BYTE) ? PH_FUNC : PH_HUNT1;
      end
      PH_FUNC: begin
        if (b == FN_HEIGHT) begin
          rx_phase = PH_HEIGHT;
          rx_count = 4'd0;
        end else if (b == FN_ATTITUDE) begin
          rx_phase = PH_ATT;
          rx_count = 4'd0;
        end else begin
          rx_phase = PH_HUNT1;
        end
      end
      PH_HEIGHT, PH_ATT: begin
        if (rx_count < STORE_DEPTH) rx_store[rx_count] = b;
        rx_count = rx_count + 4'd1;
        if (rx_count >= PAYLOAD_BYTES) begin
          frame.frame_kind  = (rx_phase == PH_ATT) ? KIND_ATTITUDE : KIND_HEIGHT;
          frame.word_first  = {rx_store[3], rx_store[2], rx_store[1], rx_store[0]};
          frame.word_second = {rx_store[7], rx_store[6], rx_store[5], rx_store[4]};
          frame.word_third  = {rx_store[11], rx_store[10], rx_store[9], rx_store[8]};
          done = 1'b1;
          rx_phase = PH_HUNT1;
        end
      end
      default: begin
        rx_phase = PH_HUNT1;
      end
    endcase
    return done;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Predict on every accepted input word and check every accepted result.
  always @(posedge clk) begin : monitor
    typed_frame_t typed;
    frame_t       predicted;
    frame_t       wanted;
    bit           produced;
    if (rst_n && in_valid && in_ready) begin
      typed = typed_frames.pop_front();
      produced = parse_rx_byte(in_rx_byte, predicted);
      if (typed.known) begin
        pending_frames.push_back(typed.frame);
      end else if (produced) begin
        pending_frames.push_back(predicted);
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        error_count++;
        $display("%0t: unexpected frame, expected none, actual kind %0d %h %h %h", $time,
                 out_frame_kind, out_word_first, out_word_second, out_word_third);
      end else begin
        wanted = pending_frames.pop_front();
        check_field("frame_kind", {31'd0, wanted.frame_kind}, {31'd0, out_frame_kind});
        check_field("word_first", wanted.word_first, out_word_first);
        check_field("word_second", wanted.word_second, out_word_second);
        check_field("word_third", wanted.word_third, out_word_third);
        if (wanted.frame_kind == KIND_ATTITUDE) attitude_checked++;
        else height_checked++;
      end
    end
  end

  // Receiver side: segments of steady, random and sparse ready, plus a long hold on request.
  initial begin : receiver
    int seg_left;
    int mode;
    int hold_left;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(4, 40);
        end
        seg_left--;
        case (mode)
          2: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          3: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready <= 1'b1;
          end
        endcase
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  // Offer one word and wait for its acceptance; the sender idles between bursts.
  task automatic offer_byte(input logic [7:0] b, input logic known = 1'b0,
                            input frame_t frame = NO_FRAME);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 19))
        0:       gap = $urandom_range(20, 40);
        1, 2, 3: gap = $urandom_range(4, 12);
        default: gap = $urandom_range(0, 3);
      endcase
      if (no_gaps) gap = 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    typed_frames.push_back('{known, frame});
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Biased byte source that often hits the extremes and the header value.
  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return HDR_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Header, random function code of either kind, then payload_len payload bytes.
  task automatic send_frame(input int payload_len);
    logic [7:0] fn;
    fn = $urandom_range(0, 1) ? FN_ATTITUDE : FN_HEIGHT;
    offer_byte(HDR_BYTE);
    offer_byte(HDR_BYTE);
    offer_byte(fn);
    for (int i = 0; i < payload_len; i++) offer_byte(random_byte());
  endtask

  // Either a bad second header byte or an unknown function byte.
  task automatic send_broken_header();
    logic [7:0] b;
    offer_byte(HDR_BYTE);
    if ($urandom_range(0, 1)) begin
      do b = random_byte(); while (b == HDR_BYTE);
      offer_byte(b);
    end else begin
      offer_byte(HDR_BYTE);
      do b = random_byte(); while (b == FN_HEIGHT || b == FN_ATTITUDE);
      offer_byte(b);
    end
  endtask

  // Stop offering words until every predicted frame has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_frames.size() != 0 || typed_frames.size() != 0);
  endtask

  initial begin : stimulus
    bit pressure_done;
    pressure_done = 1'b0;
    rx_phase = PH_HUNT1;
    rx_count = 4'd0;
    foreach (rx_store[i]) rx_store[i] = 8'h00;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_byte(DIRECTED[i].rx_byte, DIRECTED[i].known, DIRECTED[i].frame);
    end

    // Random part: mostly well-formed frames, the rest noise and broken sequences.
    while (items_sent < ITEM_TARGET) begin
      if (!pressure_done && items_sent >= 150) begin
        // Let everything drain, then keep offering frames while the receiver holds off.
        wait_drained();
        hold_req = 1'b1;
        no_gaps = 1'b1;
        repeat (3) send_frame(PAYLOAD_BYTES);
        no_gaps = 1'b0;
        pressure_done = 1'b1;
      end
      no_gaps = (items_sent >= 260 && items_sent < 340);
      case ($urandom_range(0, 9))
        7: begin
          repeat ($urandom_range(1, 5)) offer_byte(random_byte());
        end
        8: begin
          send_broken_header();
        end
        9: begin
          send_frame($urandom_range(1, PAYLOAD_BYTES - 1));
        end
        default: begin
          send_frame(PAYLOAD_BYTES);
        end
      endcase
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d words with random gaps and receiver stalls, including a long hold-off.",
             items_sent);
    $display("Checked %0d height and %0d attitude frames.", height_checked, attitude_checked);
    if (error_count == 0 && pending_frames.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
